// ===== hdl/rmq_pkg.sv =====
// Shared constants, types and helpers for the rotation matrix to quaternion block.
package rmq_pkg;

  localparam int DataW        = 16;
  localparam int NumW         = DataW + 1;
  localparam int ArgW         = DataW + 2;
  localparam int DvsW         = ArgW - 1;
  localparam int DivW         = 2 * NumW + 13;
  localparam int DiagW        = DvsW + 12;
  localparam int Lanes        = 3;
  localparam int SqLanes      = Lanes + 1;
  localparam int SqrtW        = DivW + 1;
  localparam int RootW        = SqrtW / 2;
  localparam int SremW        = RootW + 2;
  localparam int NumDivCells  = DivW;
  localparam int NumSqrtCells = RootW;

  localparam logic signed [ArgW-1:0] Q14One = ArgW'(16384);

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_ROW0  = 2'd1;
  localparam logic [1:0] BR_ROW1  = 2'd2;
  localparam logic [1:0] BR_ROW2  = 2'd3;

  typedef struct packed {
    logic [1:0]       branch;
    logic             bad;
    logic [Lanes-1:0] neg;
  } side_t;

  typedef struct packed {
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] z;
    logic [DataW-1:0] w;
    logic [1:0]       branch;
    logic             bad;
  } quat_t;

  function automatic logic signed [NumW-1:0] ext_num(logic signed [DataW-1:0] v);
    return {v[DataW-1], v};
  endfunction

  function automatic logic signed [ArgW-1:0] ext_arg(logic signed [DataW-1:0] v);
    return {{2{v[DataW-1]}}, v};
  endfunction

endpackage

// ===== hdl/rmq_ifs.sv =====
// Matrix and quaternion stream channels.
interface rmq_mat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] r0c0;
  logic signed [15:0] r0c1;
  logic signed [15:0] r0c2;
  logic signed [15:0] r1c0;
  logic signed [15:0] r1c1;
  logic signed [15:0] r1c2;
  logic signed [15:0] r2c0;
  logic signed [15:0] r2c1;
  logic signed [15:0] r2c2;
  modport source (output valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                  input ready);
  modport sink (input valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                output ready);
endinterface

interface rmq_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic [1:0]         branch_taken;
  logic               bad_input;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_taken, bad_input,
                  input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, branch_taken, bad_input,
                output ready);
endinterface

// ===== hdl/rmq_div_cell.sv =====
// One restoring division cell: one quotient bit per lane, shared divisor.
module rmq_div_cell (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  rmq_pkg::side_t                           in_side,
  input  logic [rmq_pkg::DiagW-1:0]                in_diag,
  input  logic [rmq_pkg::DvsW-1:0]                 in_dvs,
  input  logic [rmq_pkg::Lanes-1:0][rmq_pkg::DvsW-1:0] in_rem,
  input  logic [rmq_pkg::Lanes-1:0][rmq_pkg::DivW-1:0] in_bits,
  output logic                                     out_valid,
  output rmq_pkg::side_t                           out_side,
  output logic [rmq_pkg::DiagW-1:0]                out_diag,
  output logic [rmq_pkg::DvsW-1:0]                 out_dvs,
  output logic [rmq_pkg::Lanes-1:0][rmq_pkg::DvsW-1:0] out_rem,
  output logic [rmq_pkg::Lanes-1:0][rmq_pkg::DivW-1:0] out_bits
);
  import rmq_pkg::*;

  logic [Lanes-1:0][DvsW:0] trial;
  logic [Lanes-1:0][DvsW-1:0] rem_next;
  logic [Lanes-1:0][DivW-1:0] bits_next;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      trial[i] = {in_rem[i], in_bits[i][DivW-1]};
      if (trial[i] >= {1'b0, in_dvs}) begin
        rem_next[i]  = DvsW'(trial[i] - {1'b0, in_dvs});
        bits_next[i] = {in_bits[i][DivW-2:0], 1'b1};
      end else begin
        rem_next[i]  = trial[i][DvsW-1:0];
        bits_next[i] = {in_bits[i][DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_diag <= in_diag;
      out_dvs  <= in_dvs;
      out_rem  <= rem_next;
      out_bits <= bits_next;
    end
  end

endmodule

// ===== hdl/rmq_sqrt_cell.sv =====
// One digit-by-digit square root cell: one root bit per lane.
module rmq_sqrt_cell (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic                                          in_valid,
  input  rmq_pkg::side_t                                in_side,
  input  logic [rmq_pkg::SqLanes-1:0][rmq_pkg::SremW-1:0] in_rem,
  input  logic [rmq_pkg::SqLanes-1:0][rmq_pkg::RootW-1:0] in_root,
  input  logic [rmq_pkg::SqLanes-1:0][rmq_pkg::SqrtW-1:0] in_rad,
  output logic                                          out_valid,
  output rmq_pkg::side_t                                out_side,
  output logic [rmq_pkg::SqLanes-1:0][rmq_pkg::SremW-1:0] out_rem,
  output logic [rmq_pkg::SqLanes-1:0][rmq_pkg::RootW-1:0] out_root,
  output logic [rmq_pkg::SqLanes-1:0][rmq_pkg::SqrtW-1:0] out_rad
);
  import rmq_pkg::*;

  logic [SqLanes-1:0][SremW+1:0] rem_sh;
  logic [SqLanes-1:0][SremW+1:0] sub;
  logic [SqLanes-1:0][SremW-1:0] rem_next;
  logic [SqLanes-1:0][RootW-1:0] root_next;

  always_comb begin
    for (int i = 0; i < SqLanes; i++) begin
      rem_sh[i] = {in_rem[i], in_rad[i][SqrtW-1:SqrtW-2]};
      sub[i]    = {2'b00, in_root[i], 2'b01};
      if (rem_sh[i] >= sub[i]) begin
        rem_next[i]  = SremW'(rem_sh[i] - sub[i]);
        root_next[i] = {in_root[i][RootW-2:0], 1'b1};
      end else begin
        rem_next[i]  = rem_sh[i][SremW-1:0];
        root_next[i] = {in_root[i][RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_rem  <= rem_next;
      out_root <= root_next;
      for (int i = 0; i < SqLanes; i++) begin
        out_rad[i] <= {in_rad[i][SqrtW-3:0], 2'b00};
      end
    end
  end

endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// Throughput: one matrix per cycle; 2 front stages, a row of 47 divider cells and a row
// of 24 square root cells advance together, then an output register with one skid entry.
// The pipeline holds while the skid entry is full.
// Reset: synchronous, active high; clears all valid flags, payload is not reset.
module rotation_matrix_to_quaternion (
  input logic        clk,
  input logic        rst,
  rmq_mat_if.sink    mat,
  rmq_quat_if.source quat
);
  import rmq_pkg::*;

  function automatic logic [DataW-1:0] div_out(logic [RootW-1:0] r, logic neg);
    logic [RootW:0]   s;
    logic [RootW-1:0] q;
    logic [DataW-1:0] res;
    s = {1'b0, r} + (RootW+1)'(1);
    q = s[RootW:1];
    if (!neg) begin
      res = (|q[RootW-1:DataW-1]) ? 16'h7fff : q[DataW-1:0];
    end else if ((|q[RootW-1:DataW]) || (q[DataW-1] && (|q[DataW-2:0]))) begin
      res = 16'h8000;
    end else begin
      res = (~q[DataW-1:0]) + 16'd1;
    end
    return res;
  endfunction

  function automatic logic [DataW-1:0] diag_out(logic [RootW-1:0] r, logic [SremW-1:0] rem);
    logic [RootW:0] d;
    logic [DataW-1:0] res;
    d = (rem > {2'b00, r}) ? ({1'b0, r} + (RootW+1)'(1)) : {1'b0, r};
    res = (|d[RootW:DataW-1]) ? 16'h7fff : d[DataW-1:0];
    return res;
  endfunction

  logic en;
  logic ov;
  logic sv;
  quat_t ob;
  quat_t sb;
  quat_t res;

  logic f1_valid;
  logic [1:0] f1_branch;
  logic signed [ArgW-1:0] f1_arg;
  logic [Lanes-1:0][NumW-1:0] f1_num;
  logic [1:0] f1_branch_next;
  logic signed [ArgW-1:0] f1_arg_next;
  logic [Lanes-1:0][NumW-1:0] f1_num_next;
  logic signed [ArgW-1:0] tr;

  logic f2_valid;
  side_t f2_side;
  logic [DiagW-1:0] f2_diag;
  logic [DvsW-1:0] f2_dvs;
  logic [Lanes-1:0][DivW-1:0] f2_big;
  logic [Lanes-1:0][NumW-1:0] mag;
  logic [Lanes-1:0][2*NumW-1:0] sq;

  logic dv_valid [NumDivCells+1];
  side_t dv_side [NumDivCells+1];
  logic [DiagW-1:0] dv_diag [NumDivCells+1];
  logic [DvsW-1:0] dv_dvs [NumDivCells+1];
  logic [Lanes-1:0][DvsW-1:0] dv_rem [NumDivCells+1];
  logic [Lanes-1:0][DivW-1:0] dv_bits [NumDivCells+1];

  logic sq_valid [NumSqrtCells+1];
  side_t sq_side [NumSqrtCells+1];
  logic [SqLanes-1:0][SremW-1:0] sq_rem [NumSqrtCells+1];
  logic [SqLanes-1:0][RootW-1:0] sq_root [NumSqrtCells+1];
  logic [SqLanes-1:0][SqrtW-1:0] sq_rad [NumSqrtCells+1];

  logic arrive;
  logic out_fire;
  logic [DataW-1:0] l0, l1, l2, dg;
  side_t fs;

  assign en = !sv;
  assign mat.ready = en;

  always_comb begin
    tr = ext_arg(mat.r0c0) + ext_arg(mat.r1c1) + ext_arg(mat.r2c2);
    if (tr > 0) begin
      f1_branch_next = BR_TRACE;
      f1_arg_next    = Q14One + tr;
      f1_num_next[0] = ext_num(mat.r1c2) - ext_num(mat.r2c1);
      f1_num_next[1] = ext_num(mat.r2c0) - ext_num(mat.r0c2);
      f1_num_next[2] = ext_num(mat.r0c1) - ext_num(mat.r1c0);
    end else if (mat.r0c0 > mat.r1c1 && mat.r0c0 > mat.r2c2) begin
      f1_branch_next = BR_ROW0;
      f1_arg_next    = Q14One + ext_arg(mat.r0c0) - ext_arg(mat.r1c1) - ext_arg(mat.r2c2);
      f1_num_next[0] = ext_num(mat.r1c2) - ext_num(mat.r2c1);
      f1_num_next[1] = ext_num(mat.r0c1) + ext_num(mat.r1c0);
      f1_num_next[2] = ext_num(mat.r0c2) + ext_num(mat.r2c0);
    end else if (mat.r1c1 > mat.r2c2) begin
      f1_branch_next = BR_ROW1;
      f1_arg_next    = Q14One + ext_arg(mat.r1c1) - ext_arg(mat.r0c0) - ext_arg(mat.r2c2);
      f1_num_next[0] = ext_num(mat.r2c0) - ext_num(mat.r0c2);
      f1_num_next[1] = ext_num(mat.r0c1) + ext_num(mat.r1c0);
      f1_num_next[2] = ext_num(mat.r1c2) + ext_num(mat.r2c1);
    end else begin
      f1_branch_next = BR_ROW2;
      f1_arg_next    = Q14One + ext_arg(mat.r2c2) - ext_arg(mat.r0c0) - ext_arg(mat.r1c1);
      f1_num_next[0] = ext_num(mat.r0c1) - ext_num(mat.r1c0);
      f1_num_next[1] = ext_num(mat.r0c2) + ext_num(mat.r2c0);
      f1_num_next[2] = ext_num(mat.r1c2) + ext_num(mat.r2c1);
    end
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      mag[i] = f1_num[i][NumW-1] ? NumW'(-f1_num[i]) : f1_num[i];
      sq[i]  = (2*NumW)'(mag[i]) * (2*NumW)'(mag[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= mat.valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_branch <= f1_branch_next;
      f1_arg    <= f1_arg_next;
      f1_num    <= f1_num_next;
      f2_side.branch <= f1_branch;
      f2_side.bad    <= f1_arg[ArgW-1] || (f1_arg == '0);
      for (int i = 0; i < Lanes; i++) begin
        f2_side.neg[i] <= f1_num[i][NumW-1];
        f2_big[i]      <= {sq[i][DivW-15:0], 14'b0};
      end
      f2_dvs  <= f1_arg[DvsW-1:0];
      f2_diag <= {f1_arg[DvsW-1:0], 12'b0};
    end
  end

  assign dv_valid[0] = f2_valid;
  assign dv_side[0]  = f2_side;
  assign dv_diag[0]  = f2_diag;
  assign dv_dvs[0]   = f2_dvs;
  assign dv_rem[0]   = '0;
  assign dv_bits[0]  = f2_big;

  for (genvar g = 0; g < NumDivCells; g++) begin : g_div
    rmq_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[g]),
      .in_side   (dv_side[g]),
      .in_diag   (dv_diag[g]),
      .in_dvs    (dv_dvs[g]),
      .in_rem    (dv_rem[g]),
      .in_bits   (dv_bits[g]),
      .out_valid (dv_valid[g+1]),
      .out_side  (dv_side[g+1]),
      .out_diag  (dv_diag[g+1]),
      .out_dvs   (dv_dvs[g+1]),
      .out_rem   (dv_rem[g+1]),
      .out_bits  (dv_bits[g+1])
    );
  end

  assign sq_valid[0] = dv_valid[NumDivCells];
  assign sq_side[0]  = dv_side[NumDivCells];
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      sq_rad[0][i] = {1'b0, dv_bits[NumDivCells][i]};
    end
    sq_rad[0][Lanes] = SqrtW'(dv_diag[NumDivCells]);
  end

  for (genvar g = 0; g < NumSqrtCells; g++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_valid[g]),
      .in_side   (sq_side[g]),
      .in_rem    (sq_rem[g]),
      .in_root   (sq_root[g]),
      .in_rad    (sq_rad[g]),
      .out_valid (sq_valid[g+1]),
      .out_side  (sq_side[g+1]),
      .out_rem   (sq_rem[g+1]),
      .out_root  (sq_root[g+1]),
      .out_rad   (sq_rad[g+1])
    );
  end

  always_comb begin
    fs = sq_side[NumSqrtCells];
    l0 = div_out(sq_root[NumSqrtCells][0], fs.neg[0]);
    l1 = div_out(sq_root[NumSqrtCells][1], fs.neg[1]);
    l2 = div_out(sq_root[NumSqrtCells][2], fs.neg[2]);
    dg = diag_out(sq_root[NumSqrtCells][Lanes], sq_rem[NumSqrtCells][Lanes]);
    res.branch = fs.branch;
    res.bad    = fs.bad;
    case (fs.branch)
      BR_TRACE: begin
        res.x = l0; res.y = l1; res.z = l2; res.w = dg;
      end
      BR_ROW0: begin
        res.x = dg; res.y = l1; res.z = l2; res.w = l0;
      end
      BR_ROW1: begin
        res.x = l1; res.y = dg; res.z = l2; res.w = l0;
      end
      default: begin
        res.x = l1; res.y = l2; res.z = dg; res.w = l0;
      end
    endcase
    if (fs.bad) begin
      res.x = '0; res.y = '0; res.z = '0; res.w = '0;
    end
  end

  assign arrive   = en && sq_valid[NumSqrtCells];
  assign out_fire = ov && quat.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (out_fire) begin
        sv <= 1'b0;
      end
    end else if (arrive) begin
      if (ov && !quat.ready) begin
        sv <= 1'b1;
      end else begin
        ov <= 1'b1;
      end
    end else if (out_fire) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (out_fire) begin
        ob <= sb;
      end
    end else if (arrive) begin
      if (ov && !quat.ready) begin
        sb <= res;
      end else begin
        ob <= res;
      end
    end
  end

  assign quat.valid        = ov;
  assign quat.quat_x       = ob.x;
  assign quat.quat_y       = ob.y;
  assign quat.quat_z       = ob.z;
  assign quat.quat_w       = ob.w;
  assign quat.branch_taken = ob.branch;
  assign quat.bad_input    = ob.bad;

`ifndef NO_ASSERTIONS
  a_skid_has_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid entry held without an output beat");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    ov && !quat.ready |=> ov)
    else $error("output beat dropped while stalled");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.bad_input |->
      quat.quat_x == 0 && quat.quat_y == 0 && quat.quat_z == 0 && quat.quat_w == 0)
    else $error("bad input beat carries nonzero quaternion");
  a_trace_good: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.branch_taken == BR_TRACE |-> !quat.bad_input)
    else $error("trace branch flagged bad");
`endif

endmodule

// ===== verif/tb_rotation_matrix_to_quaternion.sv =====
// Self-checking testbench for the rotation matrix to quaternion converter.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  typedef logic signed [15:0] matrix_t [9];

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmq_mat_if  mat();
  rmq_quat_if quat();

  rotation_matrix_to_quaternion dut (
    .clk  (clk),
    .rst  (rst),
    .mat  (mat.sink),
    .quat (quat.source)
  );

  always #5 clk = ~clk;

  quat_t pending_quats[$];
  int    src_idle_pct;
  int    snk_idle_pct;
  int    mismatches;

  initial begin
    mat.valid  = 1'b0;
    mat.r0c0   = '0;
    mat.r0c1   = '0;
    mat.r0c2   = '0;
    mat.r1c0   = '0;
    mat.r1c1   = '0;
    mat.r1c2   = '0;
    mat.r2c0   = '0;
    mat.r2c1   = '0;
    mat.r2c2   = '0;
    quat.ready = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] clamp_q14(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] half_scale(longint a);
    longint unsigned n;
    longint unsigned r;
    n = longint'(a) << 12;
    r = int_sqrt(n);
    if (n - r * r > r) r++;
    return clamp_q14(longint'(r));
  endfunction

  function automatic logic [15:0] scaled_ratio(longint num, longint a);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? -num : num;
    q   = (int_sqrt((64'd16384 * mag * mag) / longint'(a)) + 1) >> 1;
    return clamp_q14((num < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, arg;
    quat_t q;
    a00 = m[0]; a01 = m[1]; a02 = m[2];
    a10 = m[3]; a11 = m[4]; a12 = m[5];
    a20 = m[6]; a21 = m[7]; a22 = m[8];
    tr  = a00 + a11 + a22;
    q   = '0;
    if (tr > 0) begin
      q.branch = BR_TRACE;
      arg = 16384 + tr;
    end else if (a00 > a11 && a00 > a22) begin
      q.branch = BR_ROW0;
      arg = 16384 + a00 - a11 - a22;
    end else if (a11 > a22) begin
      q.branch = BR_ROW1;
      arg = 16384 + a11 - a00 - a22;
    end else begin
      q.branch = BR_ROW2;
      arg = 16384 + a22 - a00 - a11;
    end
    q.bad = (arg <= 0);
    if (!q.bad) begin
      case (q.branch)
        BR_TRACE: begin
          q.w = half_scale(arg);
          q.x = scaled_ratio(a12 - a21, arg);
          q.y = scaled_ratio(a20 - a02, arg);
          q.z = scaled_ratio(a01 - a10, arg);
        end
        BR_ROW0: begin
          q.x = half_scale(arg);
          q.w = scaled_ratio(a12 - a21, arg);
          q.y = scaled_ratio(a01 + a10, arg);
          q.z = scaled_ratio(a02 + a20, arg);
        end
        BR_ROW1: begin
          q.y = half_scale(arg);
          q.w = scaled_ratio(a20 - a02, arg);
          q.x = scaled_ratio(a01 + a10, arg);
          q.z = scaled_ratio(a12 + a21, arg);
        end
        default: begin
          q.z = half_scale(arg);
          q.w = scaled_ratio(a01 - a10, arg);
          q.x = scaled_ratio(a02 + a20, arg);
          q.y = scaled_ratio(a12 + a21, arg);
        end
      endcase
    end
    return q;
  endfunction

  task automatic send_matrix(matrix_t m);
    while ($urandom_range(99) < src_idle_pct) begin
      mat.valid <= 1'b0;
      @(posedge clk);
    end
    mat.valid <= 1'b1;
    mat.r0c0  <= m[0];
    mat.r0c1  <= m[1];
    mat.r0c2  <= m[2];
    mat.r1c0  <= m[3];
    mat.r1c1  <= m[4];
    mat.r1c2  <= m[5];
    mat.r2c0  <= m[6];
    mat.r2c1  <= m[7];
    mat.r2c2  <= m[8];
    do @(posedge clk); while (!mat.ready);
    pending_quats.push_back(matrix_to_quat(m));
  endtask

  task automatic send_rows(int v0, int v1, int v2, int v3, int v4, int v5,
                           int v6, int v7, int v8);
    matrix_t m;
    m = '{v0[15:0], v1[15:0], v2[15:0], v3[15:0], v4[15:0], v5[15:0],
          v6[15:0], v7[15:0], v8[15:0]};
    send_matrix(m);
  endtask

  task automatic drain_quats();
    mat.valid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    quat.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    quat_t want;
    if (!rst && quat.valid && quat.ready) begin
      if (pending_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion beat at %0t", $realtime);
      end else begin
        want = pending_quats.pop_front();
        if (quat.quat_x !== want.x || quat.quat_y !== want.y ||
            quat.quat_z !== want.z || quat.quat_w !== want.w ||
            quat.branch_taken !== want.branch || quat.bad_input !== want.bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp x=%h y=%h z=%h w=%h br=%0d bad=%b, ",
                      "got x=%h y=%h z=%h w=%h br=%0d bad=%b"},
                     want.x, want.y, want.z, want.w, want.branch, want.bad,
                     quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w,
                     quat.branch_taken, quat.bad_input);
        end
      end
    end
  end

  task automatic test_directed();
    send_rows(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    send_rows(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
    send_rows(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
    send_rows(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
    send_rows(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_rows(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_rows(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_rows(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0);
    send_rows(1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0);
    send_rows(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768);
    send_rows(-32768, 32767, 32767, 32767, -32767, 32767, 32767, 32767, -32768);
    send_rows(-32767, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768);
    send_rows(32767, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_rows(-32768, -32768, -32768, -32768, 32767, -32768, -32768, -32768, -32768);
    send_rows(5, 100, -100, 7, 5, 3, -9, 11, 5);
    send_rows(0, 11585, 0, -11585, 0, 0, 0, 0, 16384);
    send_rows(-10000, 1, 2, 3, -20000, 4, 5, 6, -20000);
    send_rows(-20000, 1, 2, 3, -20000, 4, 5, 6, -10000);
  endtask

  task automatic test_random(int count);
    matrix_t m;
    int lim;
    for (int i = 0; i < count; i++) begin
      lim = ($urandom_range(3) == 0) ? 32767 : 16384;
      foreach (m[k]) begin
        if (lim == 32767) m[k] = 16'($urandom());
        else m[k] = 16'($signed($urandom_range(2 * lim)) - lim);
      end
      send_matrix(m);
    end
  endtask

  task automatic test_drain_pause();
    test_random(20);
    drain_quats();
    test_random(20);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_pct = 25;
    snk_idle_pct = 78;
    test_directed();
    test_random(400);
    test_drain_pause();
    src_idle_pct = 78;
    snk_idle_pct = 25;
    test_random(400);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(400);
    drain_quats();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_quats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rmq_pkg.sv
hdl/rmq_ifs.sv
hdl/rmq_div_cell.sv
hdl/rmq_sqrt_cell.sv
hdl/rotation_matrix_to_quaternion.sv
verif/tb_rotation_matrix_to_quaternion.sv
